[rtl/sbm_pkg.sv]
// Shared types, constants and helpers for the scanline sprite/background mixer.
// No dependencies; every other file in rtl/ imports this package.
package sbm_pkg;

	localparam int LINE_WIDTH   = 160;
	localparam int SPRITE_WIDTH = 8;
	localparam int COL_W        = 8;
	localparam int SHADE_W      = 2;
	localparam int PAL_W        = 4 * SHADE_W;
	localparam int ROW_W        = SPRITE_WIDTH * SHADE_W;

	// Screen column N is addressed by sprite position N + SPRITE_OFFSET.
	localparam logic [COL_W-1:0] SPRITE_OFFSET = COL_W'(SPRITE_WIDTH);

	typedef enum logic [1:0] {
		KIND_BG     = 2'd0,
		KIND_SPRITE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// Command broadcast from the input stage to every column cell.
	typedef struct packed {
		logic                                 valid;
		kind_t                                kind;
		logic [COL_W-1:0]                     column;
		logic [SHADE_W-1:0]                   bg_shade;
		logic [COL_W-1:0]                     sprite_x;
		logic [SPRITE_WIDTH-1:0][SHADE_W-1:0] obj_shade;
		logic                                 bg_priority;
	} cmd_t;

	function automatic logic [SHADE_W-1:0] map_shade(input logic [PAL_W-1:0] palette,
	                                                 input logic [SHADE_W-1:0] raw);
		return palette[raw*SHADE_W +: SHADE_W];
	endfunction

endpackage

[rtl/sbm_line_cell.sv]
// One column of the scanline buffer: a 2-bit shade register and its update logic.
// Depends on sbm_pkg (cmd_t, kind codes, constants).
module sbm_line_cell
	import sbm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COL_W-1:0]   col_idx,
	input  cmd_t               cmd,
	output logic [SHADE_W-1:0] cur_shade
);

	logic [SHADE_W-1:0] shade_q;
	logic [COL_W-1:0]   offset;
	logic               bg_hit;
	logic               obj_hit;
	logic [SHADE_W-1:0] obj;
	logic [SHADE_W-1:0] merged;

	// Sprite pixel j lands here when sprite_x + j == col_idx + 8 (mod 256).
	assign offset  = col_idx + SPRITE_OFFSET - cmd.sprite_x;
	assign obj_hit = cmd.valid && (cmd.kind == KIND_SPRITE)
	                 && (offset < COL_W'(SPRITE_WIDTH));
	assign bg_hit  = cmd.valid && (cmd.kind == KIND_BG) && (cmd.column == col_idx);
	assign obj     = cmd.obj_shade[offset[$clog2(SPRITE_WIDTH)-1:0]];

	always_comb begin
		if (cmd.bg_priority) begin
			merged = (shade_q != '0) ? shade_q : obj;
		end else begin
			merged = (obj != '0) ? obj : shade_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_q <= '0;
		end else if (bg_hit) begin
			shade_q <= cmd.bg_shade;
		end else if (obj_hit) begin
			shade_q <= merged;
		end
	end

	assign cur_shade = shade_q;

endmodule

[rtl/scanline_sprite_bg_mixer_core.sv]
// Top level of the scanline mixer: input register, row of column cells, result register.
// Depends on sbm_pkg and sbm_line_cell.
//
// Takes one beat per clock: busy is always low, so start is honored every cycle.
// Each beat is registered, then applied to the line buffer at the next edge, so an
// item's effect is visible to any item that follows it, back to back included.
// A read passes stage 1 and the result register, then returns on shade/read_column
// with result_valid high for exactly one cycle; there is no way to stall it, so capture
// it on that cycle. Background writes, sprite merges and kind 3 give no result.
// The line buffer is 160 flip-flop cells cleared by reset; there is no clearing
// pass. A sprite merge updates all eight covered columns in the same cycle; columns
// off the line (position below 8 or past the last column) are dropped. Write
// bg_palette only while no read result is still pending.
module scanline_sprite_bg_mixer_core
	import sbm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               bg_palette_we,
	input  logic [PAL_W-1:0]   bg_palette,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [COL_W-1:0]   column,
	input  logic [SHADE_W-1:0] raw_pixel,
	input  logic [COL_W-1:0]   sprite_x,
	input  logic [ROW_W-1:0]   sprite_row,
	input  logic [PAL_W-1:0]   sprite_palette,
	input  logic               x_flip,
	input  logic               bg_priority,
	// result channel
	output logic               result_valid,
	output logic [SHADE_W-1:0] shade,
	output logic [COL_W-1:0]   read_column
);

	logic [PAL_W-1:0]   bg_palette_q;

	// Stage 1: registered command beat.
	logic               valid_s1;
	kind_t              kind_s1;
	logic [COL_W-1:0]   column_s1;
	logic [SHADE_W-1:0] raw_pixel_s1;
	logic [COL_W-1:0]   sprite_x_s1;
	logic [ROW_W-1:0]   sprite_row_s1;
	logic [PAL_W-1:0]   sprite_palette_s1;
	logic               x_flip_s1;
	logic               bg_priority_s1;

	cmd_t               cmd;
	logic [SHADE_W-1:0] line_shade [LINE_WIDTH];
	logic [SHADE_W-1:0] read_shade;

	logic               result_valid_q;
	logic [SHADE_W-1:0] shade_q;
	logic [COL_W-1:0]   read_column_q;

	// Never stall the source: no stage can hold a beat.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_palette_q <= '0;
		end else if (bg_palette_we) begin
			bg_palette_q <= bg_palette;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Payload: capture on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1           <= kind_t'(kind);
			column_s1         <= column;
			raw_pixel_s1      <= raw_pixel;
			sprite_x_s1       <= sprite_x;
			sprite_row_s1     <= sprite_row;
			sprite_palette_s1 <= sprite_palette;
			x_flip_s1         <= x_flip;
			bg_priority_s1    <= bg_priority;
		end
	end

	// Build the broadcast command: palette-map the background pixel and all eight
	// sprite pixels, applying the mirror so obj_shade[j] is what lands at sprite_x + j.
	always_comb begin
		cmd.valid       = valid_s1;
		cmd.kind        = kind_s1;
		cmd.column      = column_s1;
		cmd.bg_shade    = map_shade(bg_palette_q, raw_pixel_s1);
		cmd.sprite_x    = sprite_x_s1;
		cmd.bg_priority = bg_priority_s1;
		for (int j = 0; j < SPRITE_WIDTH; j++) begin
			if (x_flip_s1) begin
				cmd.obj_shade[j] = map_shade(sprite_palette_s1,
					sprite_row_s1[(SPRITE_WIDTH-1-j)*SHADE_W +: SHADE_W]);
			end else begin
				cmd.obj_shade[j] = map_shade(sprite_palette_s1,
					sprite_row_s1[j*SHADE_W +: SHADE_W]);
			end
		end
	end

	// Line buffer: one cell per column, each sees the same command.
	for (genvar i = 0; i < LINE_WIDTH; i++) begin : g_col
		sbm_line_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.col_idx   (COL_W'(i)),
			.cmd       (cmd),
			.cur_shade (line_shade[i])
		);
	end

	// Read mux; columns past the line read as zero.
	assign read_shade = (column_s1 < COL_W'(LINE_WIDTH)) ? line_shade[column_s1] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1 && (kind_s1 == KIND_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && (kind_s1 == KIND_READ)) begin
			shade_q       <= read_shade;
			read_column_q <= column_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign shade        = shade_q;
	assign read_column  = read_column_q;

	// A read beat produces its strobe once it has passed stage 1 and the result register.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_READ) |=> ##1 result_valid_q)
		else $error("read beat did not produce a result");

	// No strobe without a read in stage 1 on the previous cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(valid_s1 && kind_s1 == KIND_READ))
		else $error("result strobe without a read");

	// Columns past the line always read back as zero.
	a_off_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && read_column_q >= COL_W'(LINE_WIDTH)) |-> (shade_q == '0))
		else $error("off-line read returned nonzero shade");

	// The echoed column is the column of the read beat.
	a_column_echo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (read_column_q == $past(column_s1)))
		else $error("read_column does not match the read beat");

endmodule

[tb/scanline_sprite_bg_mixer_core_test.sv]
// Self-checking testbench for scanline_sprite_bg_mixer_core: directed table, then random phases.
// Depends on sbm_pkg for kind_t and the field widths; drives the core through its ports only.
module scanline_sprite_bg_mixer_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sbm_pkg::*;

	// Step kinds of the directed table: an input beat or a palette load.
	typedef enum {STEP_BEAT, STEP_PALETTE} step_op_t;

	typedef struct {
		kind_t                kind;
		logic [COL_W-1:0]     column;
		logic [SHADE_W-1:0]   raw;
		logic [COL_W-1:0]     sx;
		logic [ROW_W-1:0]     row;
		logic [PAL_W-1:0]     pal;
		logic                 flip;
		logic                 prio;
	} beat_t;

	typedef struct {
		logic [SHADE_W-1:0]   shade;
		logic [COL_W-1:0]     column;
	} read_res_t;

	typedef struct {
		step_op_t             op;
		beat_t                b;
		logic [PAL_W-1:0]     pal_val;
		bit                   fixed;        // expected shade typed into the table
		logic [SHADE_W-1:0]   fixed_shade;
	} step_t;

	localparam int RAND_PHASES = 10;
	localparam int PHASE_BEATS = 125;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_PRINTED = 40;

	logic               clk;
	logic               arst_n;
	logic               bg_palette_we;
	logic [PAL_W-1:0]   bg_palette;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic [COL_W-1:0]   column;
	logic [SHADE_W-1:0] raw_pixel;
	logic [COL_W-1:0]   sprite_x;
	logic [ROW_W-1:0]   sprite_row;
	logic [PAL_W-1:0]   sprite_palette;
	logic               x_flip;
	logic               bg_priority;
	logic               result_valid;
	logic [SHADE_W-1:0] shade;
	logic [COL_W-1:0]   read_column;

	// Shadow of the line buffer and the background palette.
	logic [SHADE_W-1:0] line_model [LINE_WIDTH];
	logic [PAL_W-1:0]   model_pal;

	// Read results still owed by the core, oldest first.
	read_res_t          pending_reads [$];

	int                 n_errors;
	int                 n_beats;
	int                 n_reads_checked;
	int                 n_palettes;

	scanline_sprite_bg_mixer_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.bg_palette_we  (bg_palette_we),
		.bg_palette     (bg_palette),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.column         (column),
		.raw_pixel      (raw_pixel),
		.sprite_x       (sprite_x),
		.sprite_row     (sprite_row),
		.sprite_palette (sprite_palette),
		.x_flip         (x_flip),
		.bg_priority    (bg_priority),
		.result_valid   (result_valid),
		.shade          (shade),
		.read_column    (read_column)
	);

	// 2 ns clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the core hangs or a read result never shows up.
	initial begin
		#800000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (n_errors < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_errors++;
	endtask

	// Pick shade c out of a palette: bits 2c+1:2c.
	function automatic logic [SHADE_W-1:0] pal_pick(input logic [PAL_W-1:0] p,
	                                                input logic [SHADE_W-1:0] c);
		logic [PAL_W-1:0] shifted;
		shifted = p >> (int'(c) * SHADE_W);
		return shifted[SHADE_W-1:0];
	endfunction

	// Apply one beat to the shadow buffer; return 1 with the read result for a read.
	function automatic bit mix_predict(input beat_t b, output read_res_t res);
		int                 src;
		int                 col;
		logic [COL_W-1:0]   pos;
		logic [SHADE_W-1:0] pix;
		logic [SHADE_W-1:0] obj;
		logic [SHADE_W-1:0] bg;
		res.shade = '0;
		res.column = b.column;
		case (b.kind)
			KIND_BG: begin
				if (b.column < LINE_WIDTH)
					line_model[b.column] = pal_pick(model_pal, b.raw);
				return 1'b0;
			end
			KIND_SPRITE: begin
				for (int j = 0; j < SPRITE_WIDTH; j++) begin
					src = b.flip ? (SPRITE_WIDTH - 1 - j) : j;
					pix = b.row[src*SHADE_W +: SHADE_W];
					obj = pal_pick(b.pal, pix);
					// position wraps at 8 bits before the off-line test
					pos = b.sx + COL_W'(j);
					if (pos < SPRITE_WIDTH)
						continue;
					col = int'(pos) - SPRITE_WIDTH;
					if (col >= LINE_WIDTH)
						continue;
					bg = line_model[col];
					if (b.prio)
						line_model[col] = (bg != 0) ? bg : obj;
					else
						line_model[col] = (obj != 0) ? obj : bg;
				end
				return 1'b0;
			end
			KIND_READ: begin
				if (b.column < LINE_WIDTH)
					res.shade = line_model[b.column];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic beat_t make_beat(input kind_t k, input int col, input int raw,
	                                    input int sx, input int row, input int pal,
	                                    input bit flip, input bit prio);
		beat_t b;
		b.kind = k;
		b.column = COL_W'(col);
		b.raw = SHADE_W'(raw);
		b.sx = COL_W'(sx);
		b.row = ROW_W'(row);
		b.pal = PAL_W'(pal);
		b.flip = flip;
		b.prio = prio;
		return b;
	endfunction

	function automatic step_t beat_step(input beat_t b, input bit fixed, input int fshade);
		step_t s;
		s.op = STEP_BEAT;
		s.b = b;
		s.pal_val = '0;
		s.fixed = fixed;
		s.fixed_shade = SHADE_W'(fshade);
		return s;
	endfunction

	function automatic step_t palette_step(input int v);
		step_t s;
		s.op = STEP_PALETTE;
		s.b = make_beat(KIND_NONE, 0, 0, 0, 0, 0, 1'b0, 1'b0);
		s.pal_val = PAL_W'(v);
		s.fixed = 1'b0;
		s.fixed_shade = '0;
		return s;
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		int    r;
		r = $urandom_range(99);
		if (r < 30)
			b.kind = KIND_BG;
		else if (r < 62)
			b.kind = KIND_SPRITE;
		else if (r < 92)
			b.kind = KIND_READ;
		else
			b.kind = KIND_NONE;
		// mostly on-line columns, now and then past the end
		b.column = ($urandom_range(99) < 85) ? COL_W'($urandom_range(LINE_WIDTH - 1))
		                                     : COL_W'($urandom_range(255, LINE_WIDTH));
		b.raw = SHADE_W'($urandom);
		b.sx = ($urandom_range(99) < 80) ? COL_W'($urandom_range(LINE_WIDTH + 15))
		                                 : COL_W'($urandom);
		b.row = ROW_W'($urandom);
		b.pal = PAL_W'($urandom);
		b.flip = 1'($urandom);
		b.prio = 1'($urandom);
		return b;
	endfunction

	// Mostly back to back or short pauses, a few long ones.
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Present one beat at the falling edge, hold until accepted, then idle for the requested gap.
	task automatic send_beat(input beat_t b, input int gap, input bit fixed,
	                         input logic [SHADE_W-1:0] fixed_shade);
		read_res_t res;
		@(negedge clk);
		kind <= b.kind;
		column <= b.column;
		raw_pixel <= b.raw;
		sprite_x <= b.sx;
		sprite_row <= b.row;
		sprite_palette <= b.pal;
		x_flip <= b.flip;
		bg_priority <= b.prio;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		n_beats++;
		if (mix_predict(b, res)) begin
			if (fixed)
				res.shade = fixed_shade;
			pending_reads.push_back(res);
		end
		if (gap > 0) begin
			// drop start and scramble the payload: it must be ignored while idle
			@(negedge clk);
			start <= 1'b0;
			kind <= 2'($urandom);
			column <= COL_W'($urandom);
			raw_pixel <= SHADE_W'($urandom);
			sprite_x <= COL_W'($urandom);
			sprite_row <= ROW_W'($urandom);
			sprite_palette <= PAL_W'($urandom);
			x_flip <= 1'($urandom);
			bg_priority <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop issuing, wait for every owed read, then give the pipeline time to empty.
	task automatic drain_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load bg_palette only with the core idle; the shadow follows at the same point.
	task automatic load_palette(input logic [PAL_W-1:0] v);
		drain_idle();
		@(negedge clk);
		bg_palette_we <= 1'b1;
		bg_palette <= v;
		@(negedge clk);
		bg_palette_we <= 1'b0;
		model_pal = v;
		n_palettes++;
	endtask

	// Result monitor: each strobe must match the oldest owed read.
	always @(posedge clk) begin
		read_res_t want;
		if (arst_n && result_valid) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("result with none owed: shade=%0d column=%0d",
				                          shade, read_column));
			end else begin
				want = pending_reads.pop_front();
				if (shade !== want.shade)
					report_mismatch($sformatf("column %0d: shade %0d, want %0d",
					                          want.column, shade, want.shade));
				if (read_column !== want.column)
					report_mismatch($sformatf("read_column %0d, want %0d",
					                          read_column, want.column));
				n_reads_checked++;
			end
		end
	end

	initial begin
		step_t     steps [$];
		beat_t     b;
		logic [PAL_W-1:0] pal_val;

		// Drive every input to a known value and hold reset.
		arst_n = 1'b0;
		bg_palette_we = 1'b0;
		bg_palette = '0;
		start = 1'b0;
		kind = KIND_NONE;
		column = '0;
		raw_pixel = '0;
		sprite_x = '0;
		sprite_row = '0;
		sprite_palette = '0;
		x_flip = 1'b0;
		bg_priority = 1'b0;
		n_errors = 0;
		n_beats = 0;
		n_reads_checked = 0;
		n_palettes = 0;
		model_pal = '0;
		foreach (line_model[i])
			line_model[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Reads right after reset and reads past the line end
		// carry a typed shade; everything else goes through the predictor.
		steps.push_back(beat_step(make_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0), 1, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 159, 0, 0, 0, 0, 0, 0), 1, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 255, 3, 255, 'hFFFF, 'hFF, 1, 1),
		                          1, 0));
		steps.push_back(palette_step('hE4));
		steps.push_back(beat_step(make_beat(KIND_BG, 0, 3, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_BG, 159, 2, 0, 0, 0, 0, 0), 0, 0));
		// write past the line end: ignored
		steps.push_back(beat_step(make_beat(KIND_BG, 160, 3, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 159, 0, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 160, 0, 0, 0, 0, 0, 0), 1, 0));
		// sprite fully left of the line, then the X=168 case fully right of it
		steps.push_back(beat_step(make_beat(KIND_SPRITE, 0, 0, 0, 'hFFFF, 'hFF, 0, 0),
		                          0, 0));
		steps.push_back(beat_step(make_beat(KIND_SPRITE, 0, 0, 168, 'hFFFF, 'hFF, 0, 0),
		                          0, 0));
		// only the first pixel lands, on the last column, mirrored
		steps.push_back(beat_step(make_beat(KIND_SPRITE, 0, 0, 167, 'hAAA5, 'hE4, 1, 0),
		                          0, 0));
		// X+j wraps past 255: every pixel falls off
		steps.push_back(beat_step(make_beat(KIND_SPRITE, 0, 0, 252, 'hFFFF, 'hFF, 0, 0),
		                          0, 0));
		// partly clipped on the left, background priority over column 0
		steps.push_back(beat_step(make_beat(KIND_SPRITE, 0, 0, 4, 'h1B1B, 'hE4, 0, 1),
		                          0, 0));
		// all-zero sprite shades leave the background in place
		steps.push_back(beat_step(make_beat(KIND_SPRITE, 0, 0, 8, 'hFFFF, 'h00, 0, 0),
		                          0, 0));
		// unused kind with busy-looking payload: no effect, no result
		steps.push_back(beat_step(make_beat(KIND_NONE, 1, 3, 9, 'hFFFF, 'hFF, 1, 1), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 1, 0, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 3, 0, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 159, 0, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_BG, 5, 1, 0, 0, 0, 0, 0), 0, 0));
		steps.push_back(beat_step(make_beat(KIND_READ, 5, 0, 0, 0, 0, 0, 0), 0, 0));

		foreach (steps[i]) begin
			if (steps[i].op == STEP_PALETTE)
				load_palette(steps[i].pal_val);
			else
				send_beat(steps[i].b, pick_gap(1'b0), steps[i].fixed, steps[i].fixed_shade);
		end

		// Random phases, each under its own palette; the first ones hit the extremes.
		// Every fourth phase runs back to back with no idle cycles.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: pal_val = 'hFF;
				1: pal_val = 'h00;
				2: pal_val = 'h1B;
				default: pal_val = PAL_W'($urandom);
			endcase
			load_palette(pal_val);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				b = random_beat();
				send_beat(b, pick_gap(phase % 4 == 3), 1'b0, '0);
			end
		end

		drain_idle();

		$display("Covered %0d beats with %0d reads checked under %0d palette loads",
		         n_beats, n_reads_checked, n_palettes);
		$display("Mix: bg writes, sprite merges with clipping and wrap, reads, unused kind");
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/sbm_pkg.sv
rtl/sbm_line_cell.sv
rtl/scanline_sprite_bg_mixer_core.sv
tb/scanline_sprite_bg_mixer_core_test.sv
